// File: rtl/csmt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package csmt_pkg;
    localparam int MaxDim      = 1024;
    localparam int MaxVectors  = 65536;
    localparam int ElementBits = 16;
    localparam int AccBits     = 48;
    localparam int SimBits     = 16;
    localparam int NumBits     = 16;
    localparam logic signed [15:0] ThresholdReset = 16'sd27853;

    localparam logic [1:0] ErrNone      = 2'd0;
    localparam logic [1:0] ErrZeroQuery = 2'd1;
    localparam logic [1:0] ErrLength    = 2'd2;

    localparam logic [0:0] KindQuery   = 1'b0;
    localparam logic [0:0] KindStorage = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start_query;   // clear accumulators and search on a fresh query
        logic close_query;   // latch query length, clear vector accumulators
        logic acc_query;     // write store, accumulate query energy
        logic acc_storage;   // accumulate dot product and storage energy
        logic start_root;    // begin the similarity search
        logic root_step;     // one step of the similarity search
        logic finish;        // update maximum, load output register
    } t_cmd;

    typedef struct packed {
        logic root_done;
        logic out_busy;
    } t_status;
endpackage
`default_nettype wire

// File: rtl/csmt_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface csmt_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] element_value;
    logic        last_of_vector;
    logic        last_of_set;
    modport source (output valid, kind, element_value, last_of_vector, last_of_set,
                    input ready);
    modport sink   (input valid, kind, element_value, last_of_vector, last_of_set,
                    output ready);
endinterface

interface csmt_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] similarity;
    logic [15:0] vector_number;
    logic [15:0] best_similarity;
    logic [15:0] best_number;
    logic        unique_flag;
    logic [1:0]  error_code;
    logic        final_res;
    modport source (output valid, similarity, vector_number, best_similarity,
                    best_number, unique_flag, error_code, final_res, input ready);
    modport sink   (input valid, similarity, vector_number, best_similarity,
                    best_number, unique_flag, error_code, final_res, output ready);
endinterface
`default_nettype wire

// File: rtl/csmt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module csmt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: rtl/csmt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module csmt_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic               i_kind,
    input  wire logic               i_last_of_vector,
    input  wire csmt_pkg::t_status  i_status,
    output logic                    o_ready,
    output csmt_pkg::t_cmd          o_cmd
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_ACC, ST_ROOT_START, ST_ROOT, ST_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_loading, n_loading;
    logic   r_kind, n_kind, r_last, n_last;

    // One item: the query entry is fetched in ST_READ, then accumulated in ST_ACC.
    always_comb begin
        n_state   = r_state;
        n_loading = r_loading;
        n_kind    = r_kind;
        n_last    = r_last;
        o_cmd     = '0;
        o_ready   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_kind = i_kind;
                    n_last = i_last_of_vector;
                    if (i_kind == csmt_pkg::KindQuery) begin
                        if (!r_loading) begin
                            o_cmd.start_query = 1'b1;
                        end
                        n_loading = 1'b1;
                    end else if (r_loading) begin
                        o_cmd.close_query = 1'b1;
                        n_loading = 1'b0;
                    end
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                if (r_kind == csmt_pkg::KindQuery) begin
                    o_cmd.acc_query = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.acc_storage = 1'b1;
                    n_state = r_last ? ST_ROOT_START : ST_IDLE;
                end
            end
            ST_ROOT_START: begin
                if (r_kind == csmt_pkg::KindQuery) begin
                    o_cmd.close_query = 1'b1;
                    n_loading = 1'b0;
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.start_root = 1'b1;
                    n_state = ST_ROOT;
                end
            end
            ST_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (i_status.root_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!i_status.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        // A query element ending its vector closes the load after it is stored.
        if (r_state == ST_ACC && r_kind == csmt_pkg::KindQuery && r_last) begin
            n_state = ST_ROOT_START;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_loading <= 1'b0;
            r_kind    <= csmt_pkg::KindQuery;
            r_last    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_loading <= n_loading;
            r_kind    <= n_kind;
            r_last    <= n_last;
        end
    end
endmodule
`default_nettype wire

// File: rtl/csmt_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module csmt_datapath #(
    parameter int MAX_DIM     = csmt_pkg::MaxDim,
    parameter int MAX_VECTORS = csmt_pkg::MaxVectors
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire csmt_pkg::t_cmd         i_cmd,
    input  wire logic                   i_accept,
    input  wire logic signed [15:0]     i_element_value,
    input  wire logic                   i_last_of_set,
    input  wire logic signed [15:0]     i_threshold,
    output csmt_pkg::t_status           o_status,
    csmt_out_if.source                  out_ch
);
    localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CW = $clog2(MAX_DIM + 2);
    localparam int VW = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
    localparam int AB = csmt_pkg::AccBits;

    logic [CW-1:0]           r_count, r_qlen;
    logic signed [15:0]      r_x;
    logic                    r_last_set;
    logic [AB-1:0]           r_dot, r_qe, r_se;
    logic [VW-1:0]           r_vcnt, r_best_pos;
    logic signed [15:0]      r_best;
    logic                    r_have_best;
    logic                    r_in_q;
    logic [15:0]             w_rdata;
    logic signed [31:0]      w_sq;
    logic signed [31:0]      w_prod;

    csmt_ram #(.WIDTH(16), .DEPTH(MAX_DIM)) u_store (
        .i_clk  (i_clk),
        .i_we   (i_cmd.acc_query && r_count < CW'(MAX_DIM)),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata(r_x),
        .i_raddr(r_count[AW-1:0]),
        .o_rdata(w_rdata)
    );

    // Similarity search: bit-serial root over 16 bits, one bit per pass.
    // Each trial needs prod*mid^2 <= 2^30*D^2. Eq*Es and D^2 are formed
    // together by shift-add, and each trial product by shift-add.
    logic [95:0]  r_prodq;     // Eq*Es
    logic [127:0] r_rhs;       // 2^30 * D^2
    logic [15:0]  r_root;
    logic [4:0]   r_bit;
    logic         r_neg, r_zero;
    logic [31:0]  r_msq;       // mid^2
    logic [127:0] r_acc;       // partial product prod * mid^2
    logic [127:0] r_psh;       // prod shifted to the current multiplier bit
    logic [5:0]   r_mstep;
    logic [1:0]   r_phase;     // 0 form products, 1 form mid^2, 2 multiply and compare
    logic [AB-1:0] w_mag;
    logic [15:0]  w_mid;
    logic [95:0]  r_ma, r_da;
    logic [47:0]  r_mb, r_db;
    logic [95:0]  r_mr, r_dr;
    logic [5:0]   r_mi;
    logic         r_done;

    assign w_mag  = r_dot[AB-1] ? (~r_dot + AB'(1)) : r_dot;
    assign w_mid  = r_root | (16'd1 << r_bit[3:0]);
    assign w_sq   = r_x * r_x;
    assign w_prod = r_x * $signed(w_rdata);

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_x        <= i_element_value;
            r_last_set <= i_last_of_set;
        end
        r_in_q <= (r_count < r_qlen) && (r_count < CW'(MAX_DIM));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_qlen      <= '0;
            r_dot       <= '0;
            r_qe        <= '0;
            r_se        <= '0;
            r_vcnt      <= '0;
            r_best      <= '0;
            r_best_pos  <= '0;
            r_have_best <= 1'b0;
            r_done      <= 1'b0;
            r_phase     <= '0;
            out_ch.valid <= 1'b0;
        end else begin
            if (i_cmd.start_query) begin
                r_qe        <= '0;
                r_count     <= '0;
                r_dot       <= '0;
                r_se        <= '0;
                r_vcnt      <= '0;
                r_best      <= '0;
                r_best_pos  <= '0;
                r_have_best <= 1'b0;
            end
            if (i_cmd.close_query) begin
                r_qlen  <= r_count;
                r_count <= '0;
                r_dot   <= '0;
                r_se    <= '0;
            end
            if (i_cmd.acc_query && r_count < CW'(MAX_DIM)) begin
                r_count <= r_count + CW'(1);
                r_qe    <= r_qe + AB'(unsigned'(w_sq));
            end
            if (i_cmd.acc_storage) begin
                if (r_in_q) begin
                    r_dot <= r_dot + AB'(w_prod);
                end
                r_se <= r_se + AB'(unsigned'(w_sq));
                if (r_count < CW'(MAX_DIM + 1)) begin
                    r_count <= r_count + CW'(1);
                end
            end
            if (i_cmd.start_root) begin
                r_root  <= '0;
                r_bit   <= 5'd15;
                r_neg   <= r_dot[AB-1];
                r_prodq <= '0;
                r_ma    <= 96'(r_qe);
                r_mb    <= r_se;
                r_da    <= 96'(w_mag);
                r_db    <= w_mag;
                r_mr    <= '0;
                r_dr    <= '0;
                r_mi    <= '0;
                r_phase <= 2'd0;
                r_done  <= 1'b0;
                r_zero  <= (r_se == '0) || (r_qe == '0) || (r_count != r_qlen);
            end
            if (i_cmd.root_step && !r_done) begin
                case (r_phase)
                    2'd0: begin
                        // Eq*Es and D^2 by shift-add, one bit per cycle.
                        if (r_mi == 6'd48) begin
                            r_prodq <= r_mr;
                            r_rhs   <= 128'(r_dr) << 30;
                            r_phase <= 2'd1;
                        end else begin
                            if (r_mb[0]) begin
                                r_mr <= r_mr + r_ma;
                            end
                            if (r_db[0]) begin
                                r_dr <= r_dr + r_da;
                            end
                            r_ma <= r_ma << 1;
                            r_da <= r_da << 1;
                            r_mb <= r_mb >> 1;
                            r_db <= r_db >> 1;
                            r_mi <= r_mi + 6'd1;
                        end
                    end
                    2'd1: begin
                        r_msq   <= 32'(w_mid) * 32'(w_mid);
                        r_psh   <= 128'(r_prodq);
                        r_acc   <= '0;
                        r_mstep <= '0;
                        r_phase <= 2'd2;
                    end
                    2'd2: begin
                        if (r_mstep == 6'd32) begin
                            if (r_acc <= r_rhs) begin
                                r_root <= w_mid;
                            end
                            if (r_bit == 5'd0) begin
                                r_done <= 1'b1;
                            end
                            r_bit   <= r_bit - 5'd1;
                            r_phase <= 2'd1;
                        end else begin
                            if (r_msq[0]) begin
                                r_acc <= r_acc + r_psh;
                            end
                            r_psh   <= r_psh << 1;
                            r_msq   <= r_msq >> 1;
                            r_mstep <= r_mstep + 6'd1;
                        end
                    end
                    default: r_phase <= 2'd0;
                endcase
            end
            if (i_cmd.finish) begin
                logic [1:0]         v_err;
                logic signed [15:0] v_sim;
                logic signed [15:0] v_best;
                logic [VW-1:0]      v_pos;
                logic               v_have;
                v_err = csmt_pkg::ErrNone;
                if (r_qe == '0) begin
                    v_err = csmt_pkg::ErrZeroQuery;
                end else if (r_count != r_qlen) begin
                    v_err = csmt_pkg::ErrLength;
                end
                // An exact match gives a root of 32768: on the positive side it
                // saturates, on the negative side it is exactly -32768.
                if (v_err != csmt_pkg::ErrNone || r_se == '0) begin
                    v_sim = '0;
                end else if (r_neg) begin
                    v_sim = -$signed(r_root);
                end else if (r_root[15]) begin
                    v_sim = 16'sh7fff;
                end else begin
                    v_sim = $signed(r_root);
                end
                v_best = r_best;
                v_pos  = r_best_pos;
                v_have = r_have_best;
                if (v_err == csmt_pkg::ErrNone && (!r_have_best || v_sim > r_best)) begin
                    v_best = v_sim;
                    v_pos  = r_vcnt;
                    v_have = 1'b1;
                end
                out_ch.valid           <= 1'b1;
                out_ch.similarity      <= v_sim;
                out_ch.vector_number   <= 16'(r_vcnt);
                out_ch.best_similarity <= v_best;
                out_ch.best_number     <= 16'(v_pos);
                out_ch.unique_flag     <= v_have && (v_best > i_threshold);
                out_ch.error_code      <= v_err;
                out_ch.final_res       <= r_last_set;
                r_count <= '0;
                r_dot   <= '0;
                r_se    <= '0;
                if (r_last_set) begin
                    r_vcnt      <= '0;
                    r_best      <= '0;
                    r_best_pos  <= '0;
                    r_have_best <= 1'b0;
                end else begin
                    r_vcnt      <= (r_vcnt == VW'(MAX_VECTORS - 1)) ? '0 : r_vcnt + VW'(1);
                    r_best      <= v_best;
                    r_best_pos  <= v_pos;
                    r_have_best <= v_have;
                end
            end else if (out_ch.valid && out_ch.ready) begin
                out_ch.valid <= 1'b0;
            end
        end
    end

    assign o_status.root_done = r_done || r_zero;
    assign o_status.out_busy  = out_ch.valid && !out_ch.ready;
endmodule
`default_nettype wire

// File: rtl/cosine_similarity_max_threshold_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Handshake       Payload
// in_ch     in   valid/ready     kind, element_value, last_of_vector, last_of_set
// out_ch    out  valid/ready     similarity .. final_res
// APB       in   psel/penable    similarity_threshold at address 0
//
// Each element request is accepted, reads the query store, then accumulates.
// A query element that ends its vector then closes the load in a further state.
// At the end of a storage vector a bit-serial square-root search runs: a start
// step, a shift-add phase forming both wide products, 16 trial bits each tried
// by a shift-add multiply and compare, a step to see it done, a result load.
// Reset is synchronous and active low and clears all control state.
// No request is taken during the search; at its end the block waits while the
// output register still holds a result not yet taken.
module cosine_similarity_max_threshold_top #(
    parameter int MAX_DIM     = csmt_pkg::MaxDim,
    parameter int MAX_VECTORS = csmt_pkg::MaxVectors
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    csmt_in_if.sink          in_ch,
    csmt_out_if.source       out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    logic signed [15:0] r_threshold;
    csmt_pkg::t_cmd     w_cmd;
    csmt_pkg::t_status  w_status;
    logic               w_ready;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= csmt_pkg::ThresholdReset;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            r_threshold <= pwdata[15:0];
        end
    end
    assign prdata = (paddr == 2'd0) ? {{16{r_threshold[15]}}, r_threshold} : '0;

    assign in_ch.ready = w_ready;

    csmt_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (in_ch.valid),
        .i_kind          (in_ch.kind),
        .i_last_of_vector(in_ch.last_of_vector),
        .i_status        (w_status),
        .o_ready         (w_ready),
        .o_cmd           (w_cmd)
    );

    csmt_datapath #(.MAX_DIM(MAX_DIM), .MAX_VECTORS(MAX_VECTORS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_accept       (in_ch.valid && w_ready),
        .i_element_value(in_ch.element_value),
        .i_last_of_set  (in_ch.last_of_set),
        .i_threshold    (r_threshold),
        .o_status       (w_status),
        .out_ch         (out_ch)
    );
endmodule
`default_nettype wire

// File: tb/sv/cosine_similarity_max_threshold_top_tb.sv
`timescale 1ns / 1ps

typedef struct {
    logic signed [15:0] sim;
    logic [15:0]        num;
    logic signed [15:0] best;
    logic [15:0]        best_num;
    logic               uniq;
    logic [1:0]         err;
    logic               fin;
} t_sim_result;

// Keeps its own copy of the search state and predicts one result per storage
// vector end. Accepted requests go in through note_request, results are
// checked in order through check_result.
class similarity_scoreboard;
    logic signed [15:0] query_mem [csmt_pkg::MaxDim];
    int unsigned        query_len;
    int unsigned        elem_count;
    logic [47:0]        dot_sum;
    logic [47:0]        query_nrg;
    logic [47:0]        store_nrg;
    logic [15:0]        vec_count;
    logic signed [15:0] best_val;
    logic [15:0]        best_pos;
    bit                 have_best;
    bit                 loading;
    logic signed [15:0] threshold;
    t_sim_result        expected_results [$];
    int                 errors;

    function new();
        query_len  = 0;
        elem_count = 0;
        dot_sum    = '0;
        query_nrg  = '0;
        store_nrg  = '0;
        loading    = 0;
        threshold  = csmt_pkg::ThresholdReset;
        errors     = 0;
        clear_search();
    endfunction

    function void clear_search();
        vec_count = '0;
        best_val  = '0;
        best_pos  = '0;
        have_best = 0;
    endfunction

    function void close_query();
        query_len  = elem_count;
        elem_count = 0;
        dot_sum    = '0;
        store_nrg  = '0;
        loading    = 0;
    endfunction

    // Largest r in 0..32768 with r*r*Eq*Es <= 2^30*D*D, signed as the dot
    // product and saturated on the positive side.
    function logic signed [15:0] cos_q15();
        logic [47:0]  mag;
        logic [127:0] prod;
        logic [127:0] rhs;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        mag  = dot_sum[47] ? 48'(48'd0 - dot_sum) : dot_sum;
        prod = 128'(query_nrg) * 128'(store_nrg);
        rhs  = (128'(mag) * 128'(mag)) << 30;
        if (prod == 0) return '0;
        lo = 0;
        hi = 32768;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (prod * 128'(mid) * 128'(mid) <= rhs) lo = mid;
            else hi = mid - 1;
        end
        if (dot_sum[47]) return 16'(-int'(lo));
        return (lo > 32767) ? 16'sd32767 : 16'(lo);
    endfunction

    function void note_request(logic kind, logic signed [15:0] x, logic last_vec,
                               logic last_set);
        logic [47:0] sq;
        t_sim_result r;
        sq = 48'(longint'(x) * longint'(x));
        if (kind == csmt_pkg::KindQuery) begin
            if (!loading) begin
                loading    = 1;
                query_nrg  = '0;
                elem_count = 0;
                dot_sum    = '0;
                store_nrg  = '0;
                clear_search();
            end
            if (elem_count < csmt_pkg::MaxDim) begin
                query_mem[elem_count] = x;
                elem_count++;
                query_nrg = query_nrg + sq;
            end
            if (last_vec) close_query();
            return;
        end
        if (loading) close_query();
        if (elem_count < query_len && elem_count < csmt_pkg::MaxDim)
            dot_sum = dot_sum + 48'(longint'(query_mem[elem_count]) * longint'(x));
        store_nrg = store_nrg + sq;
        if (elem_count < csmt_pkg::MaxDim + 1) elem_count++;
        if (!last_vec) return;

        r.sim = '0;
        r.err = csmt_pkg::ErrNone;
        if (query_nrg == 0) r.err = csmt_pkg::ErrZeroQuery;
        else if (elem_count != query_len) r.err = csmt_pkg::ErrLength;
        else r.sim = cos_q15();
        r.num = vec_count;
        vec_count++;
        if (r.err == csmt_pkg::ErrNone && (!have_best || r.sim > best_val)) begin
            have_best = 1;
            best_val  = r.sim;
            best_pos  = r.num;
        end
        r.best     = best_val;
        r.best_num = best_pos;
        r.uniq     = have_best && (best_val > threshold);
        r.fin      = last_set;
        expected_results = {expected_results, r};
        elem_count = 0;
        dot_sum    = '0;
        store_nrg  = '0;
        if (last_set) clear_search();
    endfunction

    function void check_result(t_sim_result got);
        t_sim_result want;
        if (expected_results.size() == 0) begin
            $error("result with no expectation waiting (vector_number %0d)", got.num);
            errors++;
            return;
        end
        want = expected_results.pop_front();
        if (got.sim !== want.sim) begin
            $error("similarity: expected %0d, got %0d", want.sim, got.sim);
            errors++;
        end
        if (got.num !== want.num) begin
            $error("vector_number: expected %0d, got %0d", want.num, got.num);
            errors++;
        end
        if (got.best !== want.best) begin
            $error("best_similarity: expected %0d, got %0d", want.best, got.best);
            errors++;
        end
        if (got.best_num !== want.best_num) begin
            $error("best_number: expected %0d, got %0d", want.best_num, got.best_num);
            errors++;
        end
        if (got.uniq !== want.uniq) begin
            $error("unique_flag: expected %0d, got %0d", want.uniq, got.uniq);
            errors++;
        end
        if (got.err !== want.err) begin
            $error("error_code: expected %0d, got %0d", want.err, got.err);
            errors++;
        end
        if (got.fin !== want.fin) begin
            $error("final_res: expected %0d, got %0d", want.fin, got.fin);
            errors++;
        end
    endfunction
endclass

module cosine_similarity_max_threshold_top_tb;
    // This margin covers the square-root search on each vector, the element
    // pipeline and the output register.
    localparam int SettleCycles = 800;
    localparam int RandomItems  = 880;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    csmt_in_if  in_if ();
    csmt_out_if out_if ();

    cosine_similarity_max_threshold_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_if),
        .out_ch  (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    similarity_scoreboard scoreboard = new();

    // When set, neither side idles: requests are offered and results taken without gaps.
    bit no_gaps = 0;
    int sent_items = 0;

    // Copy of the query currently loaded, used to build storage vectors that
    // are close to it, opposite to it, or unrelated.
    logic signed [15:0] cur_query [16];
    int                 cur_len = 1;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("cosine_similarity_max_threshold_top_tb: done, errors");
        $finish;
    end

    // The result side stalls at random, except during the gap-free stretch.
    always @(negedge i_clk) begin
        out_if.ready <= no_gaps || ($urandom_range(99) >= 24);
    end

    always @(posedge i_clk) begin
        t_sim_result got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.sim      = out_if.similarity;
            got.num      = out_if.vector_number;
            got.best     = out_if.best_similarity;
            got.best_num = out_if.best_number;
            got.uniq     = out_if.unique_flag;
            got.err      = out_if.error_code;
            got.fin      = out_if.final_res;
            scoreboard.check_result(got);
        end
    end

    // Offers one request, idling now and then beforehand, and waits until it
    // is taken. valid stays high into the next request when there is no gap.
    task automatic send(logic kind, logic [15:0] value, logic last_vec, logic last_set);
        @(negedge i_clk);
        while (!no_gaps && $urandom_range(99) < 24) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid          <= 1'b1;
        in_if.kind           <= kind;
        in_if.element_value  <= value;
        in_if.last_of_vector <= last_vec;
        in_if.last_of_set    <= last_set;
        do @(posedge i_clk); while (!in_if.ready);
        scoreboard.note_request(kind, value, last_vec, last_set);
        sent_items++;
    endtask

    task automatic go_quiet();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
    endtask

    // Setup cycle, then the access cycle; pready is always high, so the
    // register takes the value at the edge that ends the access cycle.
    task automatic write_threshold(logic signed [15:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 2'd0;
        pwdata  <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        scoreboard.threshold = value;
    endtask

    // Waits until every expected result is in, then lets the block finish any
    // search that produces nothing visible.
    task automatic drain();
        go_quiet();
        while (scoreboard.expected_results.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    function automatic logic [15:0] random_element();
        case ($urandom_range(9))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'(int'($urandom_range(8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_query(int len, bit close);
        for (int i = 0; i < len; i++) begin
            cur_query[i] = random_element();
            send(csmt_pkg::KindQuery, cur_query[i], close && (i == len - 1),
                 1'($urandom_range(1)));
        end
        cur_len = len;
    endtask

    // Storage vector built against the loaded query: an exact copy, its
    // negation, a slightly disturbed copy, all zeros or unrelated values.
    task automatic send_storage(int len, bit last_set);
        int          style;
        logic [15:0] v;
        style = $urandom_range(5);
        for (int i = 0; i < len; i++) begin
            case (style)
                0:       v = (i < cur_len) ? cur_query[i] : random_element();
                1:       v = (i < cur_len) ? 16'(-cur_query[i]) : random_element();
                2:       v = (i < cur_len) ? 16'(cur_query[i] + $urandom_range(64) - 32)
                                           : random_element();
                3:       v = '0;
                default: v = random_element();
            endcase
            // A set end without a vector end is ignored by the block.
            send(csmt_pkg::KindStorage, v, i == len - 1,
                 (i == len - 1) ? last_set : ($urandom_range(9) == 0));
        end
    endtask

    task automatic directed_tests();
        // A storage vector before any query meets a zero query energy.
        send(csmt_pkg::KindStorage, 16'h1234, 1'b1, 1'b0);
        // Query at the extremes; the set end flag on a query element is ignored.
        cur_query[0] = 16'h7fff;
        cur_query[1] = 16'h8000;
        cur_query[2] = 16'h0001;
        send(csmt_pkg::KindQuery, cur_query[0], 1'b0, 1'b1);
        send(csmt_pkg::KindQuery, cur_query[1], 1'b0, 1'b0);
        send(csmt_pkg::KindQuery, cur_query[2], 1'b1, 1'b1);
        cur_len = 3;
        // Identical vector saturates at 32767.
        send(csmt_pkg::KindStorage, 16'h7fff, 1'b0, 1'b0);
        send(csmt_pkg::KindStorage, 16'h8000, 1'b0, 1'b0);
        send(csmt_pkg::KindStorage, 16'h0001, 1'b1, 1'b0);
        // Nearly opposite vector gives a large negative similarity.
        send(csmt_pkg::KindStorage, 16'h8001, 1'b0, 1'b0);
        send(csmt_pkg::KindStorage, 16'h7fff, 1'b0, 1'b0);
        send(csmt_pkg::KindStorage, 16'hffff, 1'b1, 1'b0);
        // Zero storage vector gives similarity 0.
        send(csmt_pkg::KindStorage, 16'h0000, 1'b0, 1'b0);
        send(csmt_pkg::KindStorage, 16'h0000, 1'b0, 1'b0);
        send(csmt_pkg::KindStorage, 16'h0000, 1'b1, 1'b0);
        // Too short, then too long: length errors.
        send(csmt_pkg::KindStorage, 16'h0100, 1'b0, 1'b0);
        send(csmt_pkg::KindStorage, 16'h0100, 1'b1, 1'b0);
        send(csmt_pkg::KindStorage, 16'h0100, 1'b0, 1'b1);
        send(csmt_pkg::KindStorage, 16'h0100, 1'b0, 1'b0);
        send(csmt_pkg::KindStorage, 16'h0100, 1'b0, 1'b0);
        send(csmt_pkg::KindStorage, 16'h0100, 1'b1, 1'b1);
        // A query left open is closed by the first storage element.
        cur_query[0] = 16'h4000;
        cur_query[1] = 16'hc000;
        send(csmt_pkg::KindQuery, cur_query[0], 1'b0, 1'b0);
        send(csmt_pkg::KindQuery, cur_query[1], 1'b0, 1'b0);
        cur_len = 2;
        send(csmt_pkg::KindStorage, 16'h4000, 1'b0, 1'b0);
        send(csmt_pkg::KindStorage, 16'h4000, 1'b1, 1'b1);
    endtask

    // Query longer than the store: elements past the limit are dropped, and a
    // short storage vector against it gives a length error.
    task automatic long_vectors();
        logic [15:0] q0;
        q0 = 16'($urandom);
        for (int i = 0; i < csmt_pkg::MaxDim + 2; i++)
            send(csmt_pkg::KindQuery, (i == 0) ? q0 : 16'($urandom),
                 i == csmt_pkg::MaxDim + 1, 1'b0);
        for (int i = 0; i < 3; i++)
            send(csmt_pkg::KindStorage, 16'($urandom), i == 2, 1'b1);
        cur_len = 1;
        cur_query[0] = q0;
    endtask

    // One query, then a few storage vectors, mostly of the right length.
    task automatic random_set();
        int len;
        int vectors;
        int vlen;
        len = $urandom_range(1, 8);
        if ($urandom_range(19) == 0) begin
            // All-zero query: every following vector flags it.
            for (int i = 0; i < len; i++) begin
                cur_query[i] = '0;
                send(csmt_pkg::KindQuery, 16'h0000, i == len - 1, 1'b0);
            end
            cur_len = len;
        end else begin
            send_query(len, $urandom_range(19) != 0);
        end
        vectors = $urandom_range(1, 6);
        for (int v = 0; v < vectors; v++) begin
            vlen = ($urandom_range(99) < 85) ? len : $urandom_range(1, 9);
            send_storage(vlen, (v == vectors - 1) && $urandom_range(1));
        end
    endtask

    task automatic random_phase(int items);
        int stop_at;
        stop_at = sent_items + items;
        while (sent_items < stop_at) random_set();
    endtask

    initial begin
        logic signed [15:0] thresholds [4];
        int                 start_random;
        thresholds[0] = 16'sh7fff;
        thresholds[1] = 16'sh8000;
        thresholds[2] = 16'sh0000;
        thresholds[3] = 16'($urandom);

        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        in_if.valid          = 1'b0;
        in_if.kind           = csmt_pkg::KindQuery;
        in_if.element_value  = '0;
        in_if.last_of_vector = 1'b0;
        in_if.last_of_set    = 1'b0;
        out_if.ready         = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part and the long vectors run at the reset threshold.
        directed_tests();
        long_vectors();
        start_random = sent_items;

        for (int p = 0; p < 4; p++) begin
            drain();
            write_threshold(thresholds[p]);
            // The second phase runs partly without any idling on either side.
            if (p == 1) begin
                random_phase(RandomItems / 8);
                no_gaps = 1;
                random_phase(RandomItems / 8);
                no_gaps = 0;
            end else begin
                random_phase(RandomItems / 4);
            end
        end

        drain();
        if (scoreboard.errors == 0 && scoreboard.expected_results.size() == 0) begin
            $display("cosine_similarity_max_threshold_top_tb: done, clean");
        end else begin
            $display("cosine_similarity_max_threshold_top_tb: done, errors");
        end
        $finish;
    end
endmodule
